// ===== design/u2sf_pkg.sv =====
// shared types, constants and the segment font for the utf-8 to segment display block
// no dependencies
package u2sf_pkg;

  localparam int DISPLAY_CHARS = 8;
  localparam int POS_W  = (DISPLAY_CHARS > 1) ? $clog2(DISPLAY_CHARS) : 1;
  localparam int FCNT_W = $clog2(DISPLAY_CHARS + 1);
  localparam int CP_W   = 21;
  localparam int PAT_W  = 20;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [PAT_W-1:0] PAT_SPACE    = 20'h00000;
  localparam logic [PAT_W-1:0] PAT_QUESTION = 20'h40447;
  localparam logic [PAT_W-1:0] PAT_UNKNOWN  = 20'h00001;
  localparam logic [PAT_W-1:0] PAT_IO       = 20'he3106;
  localparam logic [CP_W-1:0]  CP_QUESTION  = 21'h3F;

  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CP_W-1:0]   code;
    logic              cut;   // sequence cut short by terminator
  } cmd_t;

  localparam logic [PAT_W-1:0] ASCII_FONT [0:94] = '{
    20'h00000, 20'h000c1, 20'h08001, 20'h29585, 20'he9586, 20'he8d8c,
    20'h7b300, 20'h08000, 20'h00208, 20'h10800, 20'h38e0c, 20'h28404,
    20'h04000, 20'h20004, 20'h00040, 20'h00808,
    20'hcb400, 20'h06001, 20'he9800, 20'h69400, 20'ha8400, 20'he1400,
    20'he3400, 20'h48400, 20'heb400, 20'he9400,
    20'h08400, 20'h08800, 20'h20208, 20'h21104, 20'h10804, 20'h40447,
    20'hcb107,
    20'he2087, 20'h49587, 20'hc3102, 20'h49583, 20'he3102, 20'he2002,
    20'hc3186, 20'ha2085, 20'h49502, 20'h03181, 20'ha2208, 20'h83100,
    20'h92089, 20'h92281, 20'hc3183, 20'he2007, 20'hc3383, 20'he2207,
    20'he1186, 20'h48402, 20'h83181, 20'h82808, 20'h82a81, 20'h10a08,
    20'ha1185, 20'h4190a,
    20'h08502, 20'h10200, 20'h49400, 20'h00a00, 20'h01100, 20'h10000,
    20'h23500, 20'ha3400, 20'h23000, 20'h00585, 20'h23800, 20'h28406,
    20'he9400, 20'ha2400, 20'h00400, 20'h0b400, 20'h08608, 20'h82000,
    20'h22484, 20'h22400, 20'h23400, 20'hea000, 20'he8400, 20'h22000,
    20'he1400, 20'ha3000, 20'h03400, 20'h02800, 20'h02a80, 20'h10a08,
    20'h08185, 20'h21800,
    20'h28502, 20'h08400, 20'h49404, 20'h2080c
  };

  // cyrillic capitals from U+0410
  localparam logic [PAT_W-1:0] CYR_FONT [0:31] = '{
    20'h0088d, 20'he3186, 20'he318e, 20'hc2002, 20'h059c9, 20'he3106,
    20'h18e08, 20'h61187, 20'h82889, 20'h00001, 20'ha2208, 20'h00889,
    20'h92089, 20'ha2085, 20'hc3183, 20'hc2083,
    20'he2007, 20'hc3102, 20'h48402, 20'ha1185, 20'h9ae89, 20'h00001,
    20'h00001, 20'ha0085, 20'h8a481, 20'h8a4c1, 20'h00001, 20'h00001,
    20'h00001, 20'h00001, 20'ha2289, 20'he0887
  };

  function automatic logic [PAT_W-1:0] font_lookup(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] da;
    logic [CP_W-1:0] dc;
    logic [PAT_W-1:0] pat;
    da = cp - 21'h20;
    dc = cp - 21'h410;
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      pat = ASCII_FONT[da[6:0]];
    end else if (cp >= 21'h410 && cp <= 21'h42F) begin
      pat = CYR_FONT[dc[4:0]];
    end else if (cp == 21'h401) begin
      pat = PAT_IO;
    end else begin
      pat = PAT_UNKNOWN;
    end
    return pat;
  endfunction

  function automatic logic [2:0] to_position(input logic [POS_W-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt);
    return w[2:0];
  endfunction

endpackage

// ===== design/u2sf_front.sv =====
// byte front end: utf-8 sequence tracking and command generation
// depends on u2sf_pkg
module u2sf_front import u2sf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  output logic       push,
  output cmd_t       cmd
);

  logic [FCNT_W-1:0] chars;
  logic [FCNT_W-1:0] chars_next;
  logic [1:0]        pending;
  logic [1:0]        pending_next;
  logic [CP_W-1:0]   acc;
  logic [CP_W-1:0]   acc_next;
  logic [CP_W-1:0]   acc_shift;
  logic              room;

  assign room      = chars < FCNT_W'(DISPLAY_CHARS);
  assign acc_shift = {acc[CP_W-7:0], text_byte[5:0]};

  always_comb begin
    chars_next   = chars;
    pending_next = pending;
    acc_next     = acc;
    push         = 1'b0;
    cmd.kind     = CMD_CHAR;
    cmd.code     = {13'd0, text_byte};
    cmd.cut      = 1'b0;
    if (text_byte == 8'd0) begin
      push         = room;
      cmd.kind     = CMD_END;
      cmd.cut      = pending != 2'd0;
      chars_next   = '0;
      pending_next = 2'd0;
      acc_next     = '0;
    end else if (!room) begin
      // display full, byte dropped
    end else if (pending != 2'd0) begin
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        push       = 1'b1;
        cmd.code   = acc_shift;
        acc_next   = '0;
        chars_next = chars + FCNT_W'(1);
      end else begin
        acc_next = acc_shift;
      end
    end else if (text_byte[7] == 1'b0) begin
      push       = 1'b1;
      chars_next = chars + FCNT_W'(1);
    end else if ((text_byte & 8'hE0) == 8'hC0) begin
      acc_next     = {16'd0, text_byte[4:0]};
      pending_next = 2'd1;
    end else if ((text_byte & 8'hF0) == 8'hE0) begin
      acc_next     = {17'd0, text_byte[3:0]};
      pending_next = 2'd2;
    end else if ((text_byte & 8'hF8) == 8'hF0) begin
      acc_next     = {18'd0, text_byte[2:0]};
      pending_next = 2'd3;
    end else begin
      push       = 1'b1;
      cmd.code   = CP_QUESTION;
      chars_next = chars + FCNT_W'(1);
    end
    push = push & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars   <= '0;
      pending <= 2'd0;
      acc     <= '0;
    end else if (take) begin
      chars   <= chars_next;
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

`ifndef SYNTHESIS
  a_chars_bound: assert property (@(posedge clk) disable iff (rst)
    chars <= FCNT_W'(DISPLAY_CHARS))
    else $error("front char count beyond display");
  a_open_needs_room: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd0 |-> room)
    else $error("open sequence with display full");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    take && text_byte == 8'd0 |=> chars == '0 && pending == 2'd0)
    else $error("terminator did not clear front state");
`endif

endmodule

// ===== design/u2sf_fifo.sv =====
// short command queue between front end and pattern back end
// depends on u2sf_pkg
module u2sf_fifo import u2sf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == Q_CNT_W'(Q_DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    Q_PTR_W'(count) == Q_PTR_W'(wr_ptr - rd_ptr))
    else $error("queue count out of step with pointers");
`endif

endmodule

// ===== design/u2sf_back.sv =====
// back end: font lookup, position counting, padding and output register
// depends on u2sf_pkg
module u2sf_back import u2sf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        seg_valid,
  input  logic        seg_stall,
  output logic [19:0] segment_pattern,
  output logic [2:0]  position,
  output logic        last_position
);

  logic [POS_W-1:0] cnt;
  logic             padding;
  logic             padding_next;
  logic             can_load;
  logic             load;
  logic             at_last;
  logic [PAT_W-1:0] pat;

  assign can_load = !seg_valid || !seg_stall;
  assign at_last  = cnt == POS_W'(DISPLAY_CHARS - 1);

  always_comb begin
    pop          = 1'b0;
    load         = 1'b0;
    pat          = PAT_SPACE;
    padding_next = padding;
    if (can_load) begin
      if (padding) begin
        load         = 1'b1;
        padding_next = !at_last;
      end else if (!empty) begin
        pop  = 1'b1;
        load = 1'b1;
        unique case (head.kind)
          CMD_CHAR: begin
            pat = font_lookup(head.code);
          end
          CMD_END: begin
            pat          = head.cut ? PAT_QUESTION : PAT_SPACE;
            padding_next = !at_last;
          end
          default: begin
            pat = PAT_SPACE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
      cnt       <= '0;
      padding   <= 1'b0;
    end else begin
      padding <= padding_next;
      if (load) begin
        seg_valid <= 1'b1;
        cnt       <= at_last ? '0 : cnt + POS_W'(1);
      end else if (!seg_stall) begin
        seg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segment_pattern <= pat;
      position        <= to_position(cnt);
      last_position   <= at_last;
    end
  end

`ifndef SYNTHESIS
  a_pad_midline: assert property (@(posedge clk) disable iff (rst)
    padding |-> cnt != '0)
    else $error("padding active at first position");
  a_no_pop_while_pad: assert property (@(posedge clk) disable iff (rst)
    padding |-> !pop)
    else $error("queue popped during padding");
  a_pad_ends_last: assert property (@(posedge clk) disable iff (rst)
    $fell(padding) |-> seg_valid && last_position)
    else $error("padding ended before final position");
`endif

endmodule

// ===== design/utf8_to_segment_font.sv =====
// top level: utf-8 text bytes in, segment font patterns per display position out
// depends on u2sf_pkg, u2sf_front, u2sf_fifo, u2sf_back
//
// Takes a zero-terminated UTF-8 string one byte per word and emits one
// segment pattern word per display position for the first DISPLAY_CHARS
// characters (ASCII 0x20-0x7E and most Cyrillic capitals have glyphs,
// anything else shows pattern 1, a bad lead byte or a sequence cut by the
// terminator shows '?'); further bytes are dropped, and the terminator fills
// the unused positions with blanks. One byte is taken per cycle while the
// 4-entry command queue between the decoder and the pattern stage has room;
// the pattern stage gives one result word per cycle unless the output stalls;
// a terminator pads up to the last position while bytes keep flowing into
// the queue. Commands are registered in the queue, patterns at the output.
module utf8_to_segment_font import u2sf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  // pattern output
  output logic        seg_valid,
  input  logic        seg_stall,
  output logic [19:0] segment_pattern,
  output logic [2:0]  position,
  output logic        last_position
);

  logic take;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  // byte taken whenever the queue can hold its command
  assign text_stall = full;
  assign take       = text_valid && !full;

  u2sf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .push      (push),
    .cmd       (push_cmd)
  );

  u2sf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  u2sf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .seg_valid       (seg_valid),
    .seg_stall       (seg_stall),
    .segment_pattern (segment_pattern),
    .position        (position),
    .last_position   (last_position)
  );

endmodule
